[rtl/mbsmr_pkg.sv]
// ============================================================================
// mbsmr_pkg
// Shared types, codes and helpers for the Modbus median responder.
// ============================================================================
package mbsmr_pkg;

    localparam int SAMPLE_COUNT_DEF = 9;

    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  FUNC_READ_INPUT  = 8'h04;
    localparam logic [7:0]  REPLY_DATA_BYTES = 8'h02;
    localparam logic [7:0]  ADDR_RESET       = 8'h0B;
    localparam logic [7:0]  REG_RESET        = 8'h01;

    // configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_SERVED_REGISTER = 2'd1;

    // input operation codes
    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;

    typedef enum logic [2:0] {
        ST_REPLY_BYTE   = 3'd0,
        ST_SAMPLES_REQ  = 3'd1,
        ST_CRC_MISMATCH = 3'd2,
        ST_WRONG_ADDR   = 3'd3,
        ST_BAD_REGISTER = 3'd4
    } status_t;

    // one bit of the reflected CRC-16
    function automatic logic [15:0] crc_shift(input logic [15:0] crc);
        logic [15:0] res;
        res = {1'b0, crc[15:1]};
        if (crc[0])
        begin
            res = res ^ CRC_POLY;
        end
        return res;
    endfunction

endpackage

[rtl/modbus_slave_median_responder.sv]
// ============================================================================
// modbus_slave_median_responder
// Modbus RTU slave serving one input register with the median of samples.
// ============================================================================
// Input channel (in_valid/in_ready): operation 0 transfers a received serial
// byte, operation 1 transfers a sensor sample. Output channel
// (out_valid/out_ready) transfers status results and reply bytes.
// Configuration: cfg_write with cfg_index/cfg_data sets the slave address
// (index 0) or the served register (index 1); there is no read-back.
// Structure: one bit-serial CRC shifter does all checksum work, and in_ready
// stays low while it folds in each of the first six request bytes. The
// median is found by one shared pair of comparators that ranks each stored
// sample in turn against every stored sample, itself included; then the
// reply CRC is computed over five bytes, then seven reply transfers follow.
// in_ready is low while the block works and while a result waits in the
// output register; a stalled receiver therefore holds the input side too.
// Reset (rst_n, asynchronous) returns to idle awaiting an address byte and
// restores the reset configuration; no clearing pass is needed.
// ============================================================================
module modbus_slave_median_responder #(
    parameter int SAMPLE_COUNT = mbsmr_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [7:0]          rx_byte,
    input  logic [15:0]         sample_value,
    output logic                out_valid,
    input  logic                out_ready,
    output mbsmr_pkg::status_t  status,
    output logic [7:0]          tx_byte,
    output logic                last,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import mbsmr_pkg::*;

    localparam int CW = $clog2(SAMPLE_COUNT + 1);
    localparam int IW = $clog2(SAMPLE_COUNT);
    localparam logic [CW-1:0] N_LAST = CW'(SAMPLE_COUNT - 1);
    localparam logic [CW-1:0] N_FULL = CW'(SAMPLE_COUNT);
    localparam logic [CW-1:0] MID    = CW'(SAMPLE_COUNT / 2);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FRAME,
        PH_SAMPLE
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_LOAD,
        S_CAPT,
        S_SCAN,
        S_SEND
    } state_t;

    state_t        state_reg;
    phase_t        phase_reg;
    logic [7:0]    addr_reg;
    logic [7:0]    served_reg;
    logic [2:0]    byte_count_reg;
    logic [15:0]   crc_reg;
    logic [2:0]    bit_cnt_reg;
    logic          reply_mode_reg;
    logic [2:0]    reply_idx_reg;
    logic [7:0]    frame3_reg;
    logic [7:0]    crc_lo_reg;
    logic [CW-1:0] sample_count_reg;
    logic [CW-1:0] cand_idx_reg;
    logic [CW-1:0] scan_idx_reg;
    logic [CW-1:0] gt_cnt_reg;
    logic [CW-1:0] ge_cnt_reg;
    logic [15:0]   cand_val_reg;
    logic [15:0]   med_reg;
    logic [15:0]   rd_data_reg;
    logic          out_valid_reg;
    status_t       status_reg;
    logic [7:0]    tx_byte_reg;
    logic          last_reg;

    logic [15:0]   sample_mem [SAMPLE_COUNT];

    logic          in_xfer;
    logic          wr_en;
    logic [IW-1:0] rd_addr;
    logic          out_free;
    logic [15:0]   crc_step;
    logic [CW-1:0] gt_sum;
    logic [CW-1:0] ge_sum;

    function automatic logic [7:0] reply_byte(input logic [2:0]  idx,
                                              input logic [7:0]  addr,
                                              input logic [15:0] med,
                                              input logic [15:0] crc);
        logic [7:0] b;
        case (idx)
            3'd0:    b = addr;
            3'd1:    b = FUNC_READ_INPUT;
            3'd2:    b = REPLY_DATA_BYTES;
            3'd3:    b = med[15:8];
            3'd4:    b = med[7:0];
            3'd5:    b = crc[7:0];
            3'd6:    b = crc[15:8];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign tx_byte   = tx_byte_reg;
    assign last      = last_reg;

    assign wr_en    = in_xfer && (operation == OP_SAMPLE) && (phase_reg == PH_SAMPLE);
    assign crc_step = crc_shift(crc_reg);

    always_comb
    begin
        rd_addr = '0;
        case (state_reg)
            S_LOAD:  rd_addr = cand_idx_reg[IW-1:0];
            S_SCAN:
            begin
                if (scan_idx_reg != N_FULL)
                begin
                    rd_addr = scan_idx_reg[IW-1:0];
                end
            end
            default: rd_addr = '0;
        endcase
    end

    // rank of the sample arriving from memory against the held candidate
    assign gt_sum = gt_cnt_reg + CW'(rd_data_reg > cand_val_reg);
    assign ge_sum = ge_cnt_reg + CW'(rd_data_reg >= cand_val_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sample_mem[sample_count_reg[IW-1:0]] <= sample_value;
        end
        rd_data_reg <= sample_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_IDLE;
            addr_reg         <= ADDR_RESET;
            served_reg       <= REG_RESET;
            byte_count_reg   <= '0;
            crc_reg          <= CRC_INIT;
            bit_cnt_reg      <= '0;
            reply_mode_reg   <= 1'b0;
            reply_idx_reg    <= '0;
            frame3_reg       <= '0;
            crc_lo_reg       <= '0;
            sample_count_reg <= '0;
            cand_idx_reg     <= '0;
            scan_idx_reg     <= '0;
            gt_cnt_reg       <= '0;
            ge_cnt_reg       <= '0;
            cand_val_reg     <= '0;
            med_reg          <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= ST_REPLY_BYTE;
            tx_byte_reg      <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SLAVE_ADDRESS:   addr_reg   <= cfg_data;
                    CFG_SERVED_REGISTER: served_reg <= cfg_data;
                    default: ;
                endcase
            end

            // the send state reloads the output register itself
            if (out_valid_reg && out_ready && state_reg != S_SEND)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer && operation == OP_RX_BYTE)
                    begin
                        case (phase_reg)
                            PH_IDLE:
                            begin
                                if (rx_byte != addr_reg)
                                begin
                                    out_valid_reg <= 1'b1;
                                    status_reg    <= ST_WRONG_ADDR;
                                    tx_byte_reg   <= '0;
                                    last_reg      <= 1'b0;
                                end
                                else
                                begin
                                    crc_reg        <= CRC_INIT ^ {8'h00, rx_byte};
                                    bit_cnt_reg    <= '0;
                                    reply_mode_reg <= 1'b0;
                                    byte_count_reg <= 3'd1;
                                    phase_reg      <= PH_FRAME;
                                    state_reg      <= S_CRC;
                                end
                            end
                            PH_FRAME:
                            begin
                                if (byte_count_reg < 3'd6)
                                begin
                                    if (byte_count_reg == 3'd3)
                                    begin
                                        frame3_reg <= rx_byte;
                                    end
                                    crc_reg        <= crc_reg ^ {8'h00, rx_byte};
                                    bit_cnt_reg    <= '0;
                                    byte_count_reg <= byte_count_reg + 3'd1;
                                    state_reg      <= S_CRC;
                                end
                                else if (byte_count_reg == 3'd6)
                                begin
                                    crc_lo_reg     <= rx_byte;
                                    byte_count_reg <= 3'd7;
                                end
                                else
                                begin
                                    // final byte: judge the frame
                                    byte_count_reg <= '0;
                                    out_valid_reg  <= 1'b1;
                                    tx_byte_reg    <= '0;
                                    last_reg       <= 1'b0;
                                    if (crc_lo_reg != crc_reg[7:0] ||
                                        rx_byte != crc_reg[15:8])
                                    begin
                                        status_reg <= ST_CRC_MISMATCH;
                                        phase_reg  <= PH_IDLE;
                                    end
                                    else if (frame3_reg != served_reg)
                                    begin
                                        status_reg <= ST_BAD_REGISTER;
                                        phase_reg  <= PH_IDLE;
                                    end
                                    else
                                    begin
                                        status_reg       <= ST_SAMPLES_REQ;
                                        phase_reg        <= PH_SAMPLE;
                                        sample_count_reg <= '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    else if (wr_en)
                    begin
                        sample_count_reg <= sample_count_reg + CW'(1);
                        if (sample_count_reg == N_LAST)
                        begin
                            cand_idx_reg <= '0;
                            state_reg    <= S_LOAD;
                        end
                    end
                end

                S_CRC:
                begin
                    bit_cnt_reg <= bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg != 3'd7)
                    begin
                        crc_reg <= crc_step;
                    end
                    else if (!reply_mode_reg)
                    begin
                        crc_reg   <= crc_step;
                        state_reg <= S_IDLE;
                    end
                    else if (reply_idx_reg < 3'd4)
                    begin
                        // fold in the next reply byte
                        crc_reg <= crc_step ^ {8'h00,
                                   reply_byte(reply_idx_reg + 3'd1, addr_reg,
                                              med_reg, crc_reg)};
                        reply_idx_reg <= reply_idx_reg + 3'd1;
                    end
                    else
                    begin
                        crc_reg       <= crc_step;
                        reply_idx_reg <= '0;
                        state_reg     <= S_SEND;
                    end
                end

                S_LOAD:
                begin
                    state_reg <= S_CAPT;
                end

                S_CAPT:
                begin
                    cand_val_reg <= rd_data_reg;
                    gt_cnt_reg   <= '0;
                    ge_cnt_reg   <= '0;
                    scan_idx_reg <= '0;
                    state_reg    <= S_SCAN;
                end

                S_SCAN:
                begin
                    // first cycle only issues the read of entry zero
                    if (scan_idx_reg != '0)
                    begin
                        gt_cnt_reg <= gt_sum;
                        ge_cnt_reg <= ge_sum;
                    end
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                    if (scan_idx_reg == N_FULL)
                    begin
                        if (gt_sum <= MID && ge_sum > MID)
                        begin
                            med_reg        <= cand_val_reg;
                            crc_reg        <= CRC_INIT ^ {8'h00, addr_reg};
                            bit_cnt_reg    <= '0;
                            reply_idx_reg  <= '0;
                            reply_mode_reg <= 1'b1;
                            state_reg      <= S_CRC;
                        end
                        else
                        begin
                            cand_idx_reg <= cand_idx_reg + CW'(1);
                            state_reg    <= S_LOAD;
                        end
                    end
                end

                S_SEND:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ST_REPLY_BYTE;
                        tx_byte_reg   <= reply_byte(reply_idx_reg, addr_reg, med_reg,
                                                    crc_reg);
                        last_reg      <= (reply_idx_reg == 3'd6);
                        if (reply_idx_reg == 3'd6)
                        begin
                            reply_idx_reg    <= '0;
                            reply_mode_reg   <= 1'b0;
                            phase_reg        <= PH_IDLE;
                            sample_count_reg <= '0;
                            crc_reg          <= CRC_INIT;
                            state_reg        <= S_IDLE;
                        end
                        else
                        begin
                            reply_idx_reg <= reply_idx_reg + 3'd1;
                        end
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[bench/modbus_slave_median_responder_tb.sv]
// ============================================================================
// modbus_slave_median_responder_tb
// Self-checking bench: a directed table of requests and samples, then random
// Modbus traffic under several address/register settings. Every result is
// compared field by field with a cycle-free slave model or a pinned status.
// ============================================================================
module modbus_slave_median_responder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbsmr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int N_SAMPLES     = SAMPLE_COUNT_DEF;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 30;
    localparam int N_SETTINGS    = 5;
    localparam int SHOW_ERRORS   = 10;
    localparam int IDLE_PERCENT  = 37;

    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    typedef enum logic [1:0] {LINK_IDLE, LINK_FRAME, LINK_COLLECT} link_t;
    typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_REG} frame_kind_t;
    typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGE} spread_t;

    typedef struct packed {
        status_t    st;
        logic [7:0] tx;
        logic       last;
    } result_t;

    typedef struct {
        logic        op;
        logic [7:0]  rx;
        logic [15:0] smp;
        logic        pinned;
        status_t     want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = OP_RX_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic [15:0] sample_value = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    status_t     status;
    logic [7:0]  tx_byte;
    logic        last;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_SLAVE_ADDRESS;
    logic [7:0]  cfg_data = 8'h00;

    // typed-in expectation travelling with the current input transfer
    logic        in_pin = 1'b0;
    status_t     in_pin_st = ST_REPLY_BYTE;

    // slave model state
    logic [7:0]  cur_addr = ADDR_RESET;
    logic [7:0]  cur_reg = REG_RESET;
    link_t       link_state = LINK_IDLE;
    logic [2:0]  frame_pos = 3'd0;
    logic [7:0]  frame_buf [8];
    logic [15:0] req_crc = CRC_INIT;
    logic [15:0] sample_buf [N_SAMPLES];
    int          sample_fill = 0;

    result_t     step_results [$];
    result_t     due_results [$];
    result_t     head_result;
    row_t        directed_rows [$];

    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    bit          hold_req = 1'b0;
    int          stall_cycles = 0;
    int          err_count = 0;
    int          items_in = 0;
    int          results_out = 0;
    int          replies_done = 0;
    int          rejects_seen = 0;

    modbus_slave_median_responder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .tx_byte      (tx_byte),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, b};
        for (k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic result_t make_result(input status_t st, input logic [7:0] tx,
                                            input logic lst);
        result_t r;
        r.st   = st;
        r.tx   = tx;
        r.last = lst;
        return r;
    endfunction

    // descending order, middle entry
    function automatic logic [15:0] median_sample();
        logic [15:0] v [N_SAMPLES];
        logic [15:0] x;
        int          i;
        int          j;
        for (i = 0; i < N_SAMPLES; i++)
        begin
            v[i] = sample_buf[i];
        end
        for (i = 1; i < N_SAMPLES; i++)
        begin
            x = v[i];
            j = i - 1;
            while (j >= 0 && v[j] < x)
            begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = x;
        end
        return v[N_SAMPLES / 2];
    endfunction

    task automatic slave_step(input logic op, input logic [7:0] rx, input logic [15:0] smp);
        logic [2:0]  pos;
        logic [15:0] med;
        logic [15:0] crc;
        logic [7:0]  reply [7];
        int          i;
        step_results.delete();
        if (op == OP_RX_BYTE)
        begin
            case (link_state)
                LINK_IDLE:
                begin
                    if (rx != cur_addr)
                    begin
                        step_results.push_back(make_result(ST_WRONG_ADDR, 8'h00, 1'b0));
                    end
                    else
                    begin
                        frame_buf[0] = rx;
                        req_crc      = crc16_byte(CRC_INIT, rx);
                        frame_pos    = 3'd1;
                        link_state   = LINK_FRAME;
                    end
                end
                LINK_FRAME:
                begin
                    pos = frame_pos;
                    frame_buf[pos] = rx;
                    if (pos < 3'd6)
                    begin
                        req_crc = crc16_byte(req_crc, rx);
                    end
                    if (pos < 3'd7)
                    begin
                        frame_pos = pos + 3'd1;
                    end
                    else
                    begin
                        frame_pos  = 3'd0;
                        link_state = LINK_IDLE;
                        if (frame_buf[6] != req_crc[7:0] || frame_buf[7] != req_crc[15:8])
                        begin
                            step_results.push_back(make_result(ST_CRC_MISMATCH, 8'h00, 1'b0));
                        end
                        else if (frame_buf[3] != cur_reg)
                        begin
                            step_results.push_back(make_result(ST_BAD_REGISTER, 8'h00, 1'b0));
                        end
                        else
                        begin
                            link_state  = LINK_COLLECT;
                            sample_fill = 0;
                            step_results.push_back(make_result(ST_SAMPLES_REQ, 8'h00, 1'b0));
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (link_state == LINK_COLLECT)
        begin
            sample_buf[sample_fill] = smp;
            sample_fill++;
            if (sample_fill == N_SAMPLES)
            begin
                med      = median_sample();
                reply[0] = cur_addr;
                reply[1] = FUNC_READ_INPUT;
                reply[2] = REPLY_DATA_BYTES;
                reply[3] = med[15:8];
                reply[4] = med[7:0];
                crc = CRC_INIT;
                for (i = 0; i < 5; i++)
                begin
                    crc = crc16_byte(crc, reply[i]);
                end
                reply[5] = crc[7:0];
                reply[6] = crc[15:8];
                for (i = 0; i < 7; i++)
                begin
                    step_results.push_back(make_result(ST_REPLY_BYTE, reply[i], i == 6));
                end
                link_state  = LINK_IDLE;
                sample_fill = 0;
                req_crc     = CRC_INIT;
            end
        end
    endtask

    task automatic note_error(input string what);
        err_count++;
        if (err_count <= SHOW_ERRORS)
        begin
            $display("%s", what);
        end
    endtask

    // monitor: results first, so a transfer at this edge never meets its own cause
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_out++;
                if (last && status == ST_REPLY_BYTE)
                begin
                    replies_done++;
                end
                if (status == ST_CRC_MISMATCH || status == ST_WRONG_ADDR
                    || status == ST_BAD_REGISTER)
                begin
                    rejects_seen++;
                end
                if (due_results.size() == 0)
                begin
                    note_error($sformatf("Unexpected result: status %0d tx %02h last %0b",
                                         status, tx_byte, last));
                end
                else
                begin
                    head_result = due_results.pop_front();
                    if (status !== head_result.st || tx_byte !== head_result.tx
                        || last !== head_result.last)
                    begin
                        note_error($sformatf({"Result %0d: expected status %0d tx %02h ",
                                              "last %0b, got status %0d tx %02h last %0b"},
                                             results_out, head_result.st, head_result.tx,
                                             head_result.last, status, tx_byte, last));
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SLAVE_ADDRESS:   cur_addr = cfg_data;
                    CFG_SERVED_REGISTER: cur_reg = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
            begin
                items_in++;
                slave_step(operation, rx_byte, sample_value);
                if (in_pin)
                begin
                    due_results.push_back(make_result(in_pin_st, 8'h00, 1'b0));
                end
                else
                begin
                    foreach (step_results[k])
                    begin
                        due_results.push_back(step_results[k]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= !recv_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] rx, input logic [15:0] smp,
                             input logic pin, input status_t pin_st);
        while (send_gaps && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        rx_byte      <= rx;
        sample_value <= smp;
        in_pin       <= pin;
        in_pin_st    <= pin_st;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    function automatic logic [63:0] make_frame(input logic [7:0] addr, input logic [7:0] func,
                                              input logic [7:0] regv, input frame_kind_t kind);
        logic [63:0] f;
        logic [15:0] crc;
        int          i;
        f = {$urandom, $urandom};
        f[7:0]   = addr;
        f[15:8]  = func;
        f[31:24] = (kind == FRAME_BAD_REG) ? (regv ^ 8'($urandom_range(1, 255))) : regv;
        crc = CRC_INIT;
        for (i = 0; i < 6; i++)
        begin
            crc = crc16_byte(crc, f[8 * i +: 8]);
        end
        if (kind == FRAME_BAD_CRC)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        f[63:48] = crc;
        return f;
    endfunction

    function automatic logic [15:0] pick_sample(input spread_t spread);
        case (spread)
            SPREAD_FULL:   return 16'($urandom_range(0, 65535));
            SPREAD_NARROW: return 16'($urandom_range(0, 7));
            default:       return ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                  ^ ($urandom_range(0, 1) ? 16'h8000 : 16'h0000);
        endcase
    endfunction

    task automatic add_row(input logic op, input logic [7:0] rx, input logic [15:0] smp,
                           input logic pinned, input status_t want);
        row_t r;
        r.op     = op;
        r.rx     = rx;
        r.smp    = smp;
        r.pinned = pinned;
        r.want   = want;
        directed_rows.push_back(r);
    endtask

    task automatic add_frame_rows(input logic [63:0] f, input status_t want);
        int k;
        for (k = 0; k < 7; k++)
        begin
            add_row(OP_RX_BYTE, f[8 * k +: 8], 16'h0000, 1'b0, ST_REPLY_BYTE);
        end
        add_row(OP_RX_BYTE, f[63:56], 16'hFFFF, 1'b1, want);
    endtask

    task automatic load_config(input logic [7:0] addr, input logic [7:0] regv);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SLAVE_ADDRESS;
        cfg_data  <= addr;
        @(negedge clk);
        cfg_index <= CFG_SERVED_REGISTER;
        cfg_data  <= regv;
        @(negedge clk);
        // a spare index must leave both registers alone
        cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
        cfg_data  <= 8'($urandom_range(0, 255));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_traffic(input logic [7:0] addr, input logic [7:0] regv, input bit squeeze);
        int          done;
        int          pick;
        int          k;
        int          cut;
        logic [63:0] f;
        frame_kind_t kind;
        spread_t     spread;
        done = 0;
        while (done < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                send_item(OP_RX_BYTE, addr ^ 8'($urandom_range(1, 255)),
                          16'($urandom_range(0, 65535)), 1'b0, ST_REPLY_BYTE);
                done++;
            end
            else if (pick < 16)
            begin
                // dropped outside collection
                send_item(OP_SAMPLE, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)), 1'b0, ST_REPLY_BYTE);
            end
            else if (pick < 22)
            begin
                // cut a frame short; the bytes that follow complete it out of line
                f   = make_frame(addr, FUNC_READ_INPUT, regv, FRAME_GOOD);
                cut = $urandom_range(1, 7);
                for (k = 0; k < cut; k++)
                begin
                    send_item(OP_RX_BYTE, f[8 * k +: 8], 16'($urandom_range(0, 65535)),
                              1'b0, ST_REPLY_BYTE);
                end
                done += cut;
            end
            else
            begin
                kind = (pick < 34) ? FRAME_BAD_CRC : (pick < 46) ? FRAME_BAD_REG : FRAME_GOOD;
                f = make_frame(addr, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                  : FUNC_READ_INPUT,
                               regv, kind);
                if (squeeze && kind == FRAME_GOOD)
                begin
                    hold_req = 1'b1;
                    squeeze  = 1'b0;
                end
                for (k = 0; k < 8; k++)
                begin
                    send_item(OP_RX_BYTE, f[8 * k +: 8], 16'($urandom_range(0, 65535)),
                              1'b0, ST_REPLY_BYTE);
                end
                done += 8;
                if (kind == FRAME_GOOD)
                begin
                    spread = spread_t'($urandom_range(0, 2));
                    for (k = 0; k < N_SAMPLES; k++)
                    begin
                        if ($urandom_range(0, 99) < 15)
                        begin
                            send_item(OP_RX_BYTE, 8'($urandom_range(0, 255)),
                                      16'($urandom_range(0, 65535)), 1'b0, ST_REPLY_BYTE);
                        end
                        send_item(OP_SAMPLE, 8'($urandom_range(0, 255)), pick_sample(spread),
                                  1'b0, ST_REPLY_BYTE);
                    end
                    done += N_SAMPLES;
                end
            end
        end
    endtask

    initial
    begin
        logic [7:0] addr_set [N_SETTINGS];
        logic [7:0] reg_set [N_SETTINGS];
        int         s;

        addr_set[0] = ADDR_RESET;
        reg_set[0]  = REG_RESET;
        addr_set[1] = 8'h00;
        reg_set[1]  = 8'h00;
        addr_set[2] = 8'hFF;
        reg_set[2]  = 8'hFF;
        addr_set[3] = 8'($urandom_range(0, 255));
        reg_set[3]  = 8'($urandom_range(0, 255));
        addr_set[4] = 8'($urandom_range(0, 255));
        reg_set[4]  = 8'($urandom_range(0, 255));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, run with the reset configuration
        add_row(OP_RX_BYTE, 8'h00, 16'h0000, 1'b1, ST_WRONG_ADDR);
        add_row(OP_RX_BYTE, 8'hFF, 16'hFFFF, 1'b1, ST_WRONG_ADDR);
        add_row(OP_SAMPLE, 8'hAA, 16'hFFFF, 1'b0, ST_REPLY_BYTE);
        add_frame_rows(make_frame(ADDR_RESET, FUNC_READ_INPUT, REG_RESET, FRAME_GOOD),
                       ST_SAMPLES_REQ);
        add_row(OP_RX_BYTE, ADDR_RESET, 16'h5555, 1'b0, ST_REPLY_BYTE);
        add_row(OP_SAMPLE, 8'h55, 16'h0000, 1'b0, ST_REPLY_BYTE);
        add_row(OP_SAMPLE, 8'h00, 16'hFFFF, 1'b0, ST_REPLY_BYTE);
        add_row(OP_SAMPLE, 8'h00, 16'h8000, 1'b0, ST_REPLY_BYTE);
        add_row(OP_SAMPLE, 8'h00, 16'h7FFF, 1'b0, ST_REPLY_BYTE);
        add_row(OP_SAMPLE, 8'h00, 16'h00FF, 1'b0, ST_REPLY_BYTE);
        add_row(OP_SAMPLE, 8'h00, 16'hFF00, 1'b0, ST_REPLY_BYTE);
        add_row(OP_SAMPLE, 8'h00, 16'h1234, 1'b0, ST_REPLY_BYTE);
        add_row(OP_SAMPLE, 8'h00, 16'hFFFF, 1'b0, ST_REPLY_BYTE);
        add_row(OP_SAMPLE, 8'h00, 16'h0000, 1'b0, ST_REPLY_BYTE);
        add_frame_rows(make_frame(ADDR_RESET, FUNC_READ_INPUT, REG_RESET, FRAME_BAD_CRC),
                       ST_CRC_MISMATCH);
        add_frame_rows(make_frame(ADDR_RESET, FUNC_READ_INPUT, REG_RESET, FRAME_BAD_REG),
                       ST_BAD_REGISTER);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].smp,
                      directed_rows[i].pinned, directed_rows[i].want);
        end
        drain();

        for (s = 0; s < N_SETTINGS; s++)
        begin
            load_config(addr_set[s], reg_set[s]);
            // one setting runs flat out on both sides
            send_gaps = (s != 2);
            recv_gaps = (s != 2);
            run_traffic(addr_set[s], reg_set[s], s == 0);
            drain();
        end

        if (due_results.size() != 0)
        begin
            note_error($sformatf("%0d expected results never arrived", due_results.size()));
        end

        $display("Run covered %0d input and %0d result transfers over %0d register settings,",
                 items_in, results_out, N_SETTINGS);
        $display("with %0d complete replies, %0d rejected requests and %0d mismatches.",
                 replies_done, rejects_seen, err_count);
        if (err_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mbsmr_pkg.sv
rtl/modbus_slave_median_responder.sv
bench/modbus_slave_median_responder_tb.sv
